// File: rtl/pps_pkg.sv
// Shared types, constants and tables of the pure pursuit steering block.
package pps_pkg;

	localparam int PATH_DEPTH = 1024;
	localparam int IDX_W = $clog2(PATH_DEPTH);
	localparam int LEN_W = IDX_W + 1;
	localparam int CORDIC_STEPS = 24;
	localparam logic [31:0] SPEED_FLOOR = 32'd66;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef enum logic [1:0] {
		REQ_PATH = 2'd0,
		REQ_ODOM = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_POSE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ZERO_LD = 2'd3
	} status_t;

	localparam logic [1:0] CFG_GAIN = 2'd0;
	localparam logic [1:0] CFG_OFFSET = 2'd1;
	localparam logic [1:0] CFG_DEFSPEED = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [9:0] path_index;
		logic path_last;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [31:0] speed;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] linear_speed;
		logic signed [31:0] angular_speed;
		logic [9:0] target_index;
		logic [1:0] status;
	} rsp_item_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/pps_if.sv
// Valid/ready stream interface carrying one item per beat.
interface pps_if #(parameter type item_t = logic) ();
	logic valid;
	logic ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pure_pursuit_steering.sv
// Pure pursuit steering: waypoint store, pose registers and the compute sequencer.
// A compute beat with no pose or an empty path goes straight to the output state.
// Otherwise one waypoint is read per cycle from the waypoint memory in the
// nearest-point scan, and again in the lookahead scan. Each scan drains a
// three-stage squared-distance pipeline. Between the scans the lookahead square
// is built in three partial products. Then come 24 steps of a shared CORDIC for
// the bearing, 24 for the sine, and a 64-step restoring divider for the turn rate.
// The input is stalled while a result waits in the output register. The waypoint
// memory has no reset; reading a slot below the path length that was never
// written gives an undefined target.
module pure_pursuit_steering (
	input logic clk,
	input logic arst_n,
	pps_if.sink req,
	pps_if.source rsp,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_data
);
	import pps_pkg::*;

	// Mirror angles beyond a quarter turn so the rotation stays in range.
	function automatic logic signed [15:0] fold_angle(input logic signed [15:0] a);
		logic signed [15:0] r;
		if (a > 16'sd16384) r = 16'sh8000 - a;
		else if (a < -16'sd16384) r = 16'sh8000 - a;
		else r = a;
		return r;
	endfunction

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_SCAN1 = 11'b00000000010,
		S_LD2 = 11'b00000000100,
		S_SCAN2 = 11'b00000001000,
		S_RDT = 11'b00000010000,
		S_BEAR = 11'b00000100000,
		S_SIN = 11'b00001000000,
		S_MUL = 11'b00010000000,
		S_DIV = 11'b00100000000,
		S_OUT = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] mem_x [PATH_DEPTH];
	logic signed [31:0] mem_y [PATH_DEPTH];
	logic signed [31:0] rd_x_q, rd_y_q;
	logic [IDX_W-1:0] rd_addr;
	logic rd_en;

	logic [30:0] gain_q, offset_q, defspd_q;
	logic [LEN_W-1:0] len_q;
	logic signed [31:0] rx_q, ry_q, rspd_q;
	logic signed [15:0] rhd_q;
	logic pose_q;

	logic [31:0] v_q;
	logic [47:0] ld_q;
	logic [LEN_W-1:0] ctr_q;
	logic [LEN_W-1:0] sent_q, sent_s1, sent_s2;
	logic vld_s1, vld_s2, vld_s3;
	logic [63:0] sqx_s1, sqy_s1;
	logic [64:0] d_s2;
	logic [95:0] best_q, ld2_q;
	logic [IDX_W-1:0] near_q, tgt_q;
	logic found_q;

	logic signed [35:0] cx_q, cy_q;
	logic [31:0] acc_q;
	logic [4:0] step_q;
	logic [63:0] num_q, rem_q, quo_q;
	logic [63:0] den_q;
	logic neg_q;
	logic [6:0] dstep_q;
	logic [31:0] smag_q;

	rsp_item_t out_q;
	logic out_v_q;

	assign req.ready = (state_q == S_IDLE) && !(out_v_q && !rsp.ready);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	wire accept = req.valid && req.ready;
	wire [1:0] kind = req.data.req_type;

	// Waypoint memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && kind == REQ_PATH) begin
			mem_x[req.data.path_index[IDX_W-1:0]] <= req.data.pos_x;
			mem_y[req.data.path_index[IDX_W-1:0]] <= req.data.pos_y;
		end
		if (rd_en) begin
			rd_x_q <= mem_x[rd_addr];
			rd_y_q <= mem_y[rd_addr];
		end
	end

	always_comb begin
		rd_en = (state_q == S_SCAN1) || (state_q == S_SCAN2) || (state_q == S_RDT);
		rd_addr = (state_q == S_RDT) ? tgt_q : ctr_q[IDX_W-1:0];
	end

	// Squared-distance pipeline: read data, then squares, then sum.
	logic signed [33:0] dxa, dya;
	logic [32:0] mx, my;
	always_comb begin
		dxa = 34'(rd_x_q) - 34'(rx_q);
		dya = 34'(rd_y_q) - 34'(ry_q);
		mx = dxa[33] ? 33'(-dxa) : dxa[32:0];
		my = dya[33] ? 33'(-dya) : dya[32:0];
	end

	// CORDIC step shared between vectoring and rotation.
	logic signed [35:0] xs, ys;
	logic [31:0] at;
	always_comb begin
		xs = cx_q >>> step_q;
		ys = cy_q >>> step_q;
		at = atan_lut(step_q);
	end

	logic [64:0] rem_sh;
	always_comb rem_sh = {rem_q, num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gain_q <= 31'd65536;
			offset_q <= 31'd6554;
			defspd_q <= 31'd32768;
			len_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			rhd_q <= '0;
			rspd_q <= '0;
			pose_q <= 1'b0;
			out_v_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rsp.ready) out_v_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN: gain_q <= cfg_data;
					CFG_OFFSET: offset_q <= cfg_data;
					CFG_DEFSPEED: defspd_q <= cfg_data;
					default: ;
				endcase
			end
			vld_s1 <= 1'b0;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							REQ_PATH: begin
								if (req.data.path_last)
									len_q <= LEN_W'({1'b0, req.data.path_index}) + 1'b1;
								state_q <= S_WAIT;
							end
							REQ_ODOM: begin
								rx_q <= req.data.pos_x;
								ry_q <= req.data.pos_y;
								rhd_q <= req.data.heading;
								rspd_q <= req.data.speed;
								pose_q <= 1'b1;
								state_q <= S_WAIT;
							end
							REQ_COMPUTE: begin
								if (!pose_q) begin
									out_q <= '{linear_speed: '0, angular_speed: '0,
										target_index: '0, status: ST_NO_POSE};
									state_q <= S_OUT;
								end else if (len_q == '0) begin
									out_q <= '{linear_speed: '0, angular_speed: '0,
										target_index: '0, status: ST_EMPTY};
									state_q <= S_OUT;
								end else begin
									out_q <= '0;
									v_q <= (rspd_q < $signed(SPEED_FLOOR)) ? {1'b0, defspd_q}
										: rspd_q;
									ctr_q <= '0;
									best_q <= '1;
									near_q <= '0;
									state_q <= S_MUL;
									step_q <= '0;
								end
							end
							default: state_q <= S_WAIT;
						endcase
					end
				end
				S_WAIT: state_q <= S_IDLE;
				S_MUL: begin
					// Lookahead from gain, chosen speed and offset.
					ld_q <= 48'((64'(gain_q) * 64'(v_q)) >> 16) + 48'(offset_q);
					state_q <= S_SCAN1;
				end
				S_SCAN1, S_SCAN2: begin
					if (ctr_q < len_q) begin
						sent_q <= ctr_q;
						ctr_q <= ctr_q + 1'b1;
					end
					vld_s1 <= (ctr_q < len_q) && !(state_q == S_SCAN2 && found_q);
					sent_s1 <= sent_q;
					sent_s2 <= sent_s1;
					sqx_s1 <= 64'(mx) * 64'(mx);
					sqy_s1 <= 64'(my) * 64'(my);
					d_s2 <= 65'(sqx_s1) + 65'(sqy_s1);
					if (vld_s3) begin
						if (state_q == S_SCAN1) begin
							if (96'(d_s2) < best_q) begin
								best_q <= 96'(d_s2);
								near_q <= sent_s2[IDX_W-1:0];
							end
						end else if (!found_q && 96'(d_s2) >= ld2_q) begin
							found_q <= 1'b1;
							tgt_q <= sent_s2[IDX_W-1:0];
						end
					end
					if (ctr_q >= len_q && !vld_s1 && !vld_s2 && !vld_s3
						&& !(rd_en && sent_q == ctr_q)) begin
						if (state_q == S_SCAN1) state_q <= S_LD2;
						else state_q <= S_RDT;
					end
				end
				S_LD2: begin
					// The lookahead square is built from its low and high parts.
					case (step_q)
						5'd0: ld2_q <= 96'(64'(ld_q[31:0]) * 64'(ld_q[31:0]));
						5'd1: ld2_q <= ld2_q
							+ {15'd0, 48'(ld_q[47:32]) * 48'(ld_q[31:0]), 33'd0};
						default: ld2_q <= ld2_q
							+ {32'(ld_q[47:32]) * 32'(ld_q[47:32]), 64'd0};
					endcase
					ctr_q <= LEN_W'(near_q);
					found_q <= 1'b0;
					tgt_q <= len_q[IDX_W-1:0] - 1'b1;
					if (step_q == 5'd2) begin
						step_q <= '0;
						state_q <= S_SCAN2;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_RDT: begin
					out_q.linear_speed <= v_q;
					out_q.target_index <= 10'(tgt_q);
					if (ld_q == '0) begin
						out_q.status <= ST_ZERO_LD;
						state_q <= S_OUT;
					end else begin
						step_q <= '0;
						acc_q <= '0;
						state_q <= S_BEAR;
					end
					found_q <= 1'b0;
				end
				S_BEAR: begin
					if (!found_q) begin
						// Load and pre-rotate into the right half plane; a target on the robot skips to the sine.
						found_q <= 1'b1;
						if (dxa == 0 && dya == 0) begin
							cx_q <= 36'(CORDIC_GAIN_Q30);
							cy_q <= '0;
							state_q <= S_SIN;
							step_q <= '0;
							acc_q <= {fold_angle(16'sd0 - rhd_q), 16'd0};
						end else if (dxa < 0) begin
							if (dya >= 0) begin
								cx_q <= 36'(dya); cy_q <= -36'(dxa); acc_q <= QUARTER_TURN;
							end else begin
								cx_q <= -36'(dya); cy_q <= 36'(dxa); acc_q <= 32'(0) - QUARTER_TURN;
							end
						end else begin
							cx_q <= 36'(dxa); cy_q <= 36'(dya);
						end
					end else begin
						if (cy_q >= 0) begin
							cx_q <= cx_q + ys; cy_q <= cy_q - xs; acc_q <= acc_q + at;
						end else begin
							cx_q <= cx_q - ys; cy_q <= cy_q + xs; acc_q <= acc_q - at;
						end
						step_q <= step_q + 1'b1;
						if (step_q == 5'(CORDIC_STEPS - 1)) begin
							logic [31:0] ar;
							logic signed [15:0] a;
							ar = acc_q + (cy_q >= 0 ? at : -at) + 32'h8000;
							a = $signed(ar[31:16]) - rhd_q;
							cx_q <= 36'(CORDIC_GAIN_Q30);
							cy_q <= '0;
							acc_q <= {fold_angle(a), 16'd0};
							step_q <= '0;
							state_q <= S_SIN;
						end
					end
				end
				S_SIN: begin
					// Rotation mode; acc_q holds the residual angle.
					if (!acc_q[31]) begin
						cx_q <= cx_q - ys; cy_q <= cy_q + xs; acc_q <= acc_q - at;
					end else begin
						cx_q <= cx_q + ys; cy_q <= cy_q - xs; acc_q <= acc_q + at;
					end
					step_q <= step_q + 1'b1;
					if (step_q == 5'(CORDIC_STEPS - 1)) begin
						logic signed [35:0] yf;
						yf = !acc_q[31] ? cy_q + xs : cy_q - xs;
						neg_q <= yf[35];
						smag_q <= yf[35] ? 32'(-yf) : 32'(yf);
						state_q <= S_DIV;
						dstep_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						den_q <= 64'(ld_q) << 14;
						num_q <= '0;
						found_q <= 1'b0;
					end
				end
				S_DIV: begin
					if (!found_q) begin
						found_q <= 1'b1;
						num_q <= (64'(v_q) << 1) * 64'(smag_q);
					end else begin
						num_q <= num_q << 1;
						if (65'(rem_sh) >= 65'(den_q)) begin
							rem_q <= 64'(rem_sh - 65'(den_q));
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
						dstep_q <= dstep_q + 1'b1;
						if (dstep_q == 7'd63) state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_q.status == ST_OK && ld_q != '0 && pose_q && len_q != '0) begin
						if (!neg_q)
							out_q.angular_speed <= (quo_q > 64'h7FFFFFFF) ? 32'h7FFFFFFF
								: quo_q[31:0];
						else
							out_q.angular_speed <= (quo_q > 64'h80000000) ? 32'h80000000
								: 32'(0) - quo_q[31:0];
					end
					if (!out_v_q || rsp.ready) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/pps_checker.sv
// Port-level checks of the steering block, bound to its top level.
module pps_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic [31:0] rsp_angular
);
	import pps_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("result beat dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("second beat taken at once");
	a_nopose: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NO_POSE || rsp_status == ST_EMPTY
			|| rsp_status == ST_ZERO_LD) |-> rsp_angular == '0)
		else $error("turn rate set on error status");
endmodule

bind pure_pursuit_steering pps_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.data.status), .rsp_angular(rsp.data.angular_speed)
);

// File: bench/tb_pure_pursuit_steering.sv
// Testbench for the pure pursuit steering block: scoreboard, stimulus and checking.
module tb_pure_pursuit_steering;
	import pps_pkg::*;

	localparam int WATCHDOG_LIMIT = 60000;

	class steer_scoreboard;
		logic signed [31:0] wp_x [PATH_DEPTH];
		logic signed [31:0] wp_y [PATH_DEPTH];
		int unsigned path_len;
		logic signed [31:0] rob_x, rob_y, rob_speed;
		logic signed [15:0] rob_heading;
		bit pose_ok;
		logic [63:0] gain, offset, def_speed;
		rsp_item_t steer_q[$];
		int errors;

		function new();
			path_len = 0;
			rob_x = 0;
			rob_y = 0;
			rob_speed = 0;
			rob_heading = 0;
			pose_ok = 0;
			gain = 64'd65536;
			offset = 64'd6554;
			def_speed = 64'd32768;
			errors = 0;
		endfunction

		function void set_cfg(logic [1:0] idx, logic [30:0] val);
			case (idx)
				CFG_GAIN: gain = 64'(val);
				CFG_OFFSET: offset = 64'(val);
				CFG_DEFSPEED: def_speed = 64'(val);
				default: ;
			endcase
		endfunction

		function int pending();
			return steer_q.size();
		endfunction

		function logic [127:0] dist_sq(int i);
			longint dx, dy;
			logic [127:0] ax, ay;
			dx = longint'(wp_x[i]) - longint'(rob_x);
			dy = longint'(wp_y[i]) - longint'(rob_y);
			ax = 128'(dx < 0 ? -dx : dx);
			ay = 128'(dy < 0 ? -dy : dy);
			return ax * ax + ay * ay;
		endfunction

		function logic signed [15:0] bearing_of(longint dx, longint dy);
			logic [31:0] acc;
			longint x, y, t, xs, ys;
			acc = 0;
			x = dx;
			y = dy;
			if (dx == 0 && dy == 0) return 16'sd0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; acc = QUARTER_TURN;
				end else begin
					t = x; x = -y; y = t; acc = 32'd0 - QUARTER_TURN;
				end
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; acc = acc + atan_lut(5'(i));
				end else begin
					x = x - ys; y = y + xs; acc = acc - atan_lut(5'(i));
				end
			end
			acc = acc + 32'h8000;
			return acc[31:16];
		endfunction

		// Sine in Q30; angles past a quarter turn are mirrored first.
		function longint sine_q30(logic signed [15:0] a);
			int aa;
			longint x, y, z, xs, ys;
			aa = a;
			if (aa > 16384) aa = 32768 - aa;
			else if (aa < -16384) aa = -32768 - aa;
			x = longint'(CORDIC_GAIN_Q30);
			y = 0;
			z = longint'(aa) * 65536;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys; y = y + xs; z = z - longint'(atan_lut(5'(i)));
				end else begin
					x = x + ys; y = y - xs; z = z + longint'(atan_lut(5'(i)));
				end
			end
			return y;
		endfunction

		function void note_req(req_item_t it);
			rsp_item_t r;
			logic [63:0] v, ld, num, den, q, ms;
			logic [127:0] best, d, ld2;
			int unsigned nearest, target;
			logic signed [15:0] alpha;
			longint s;
			case (req_t'(it.req_type))
				REQ_PATH: begin
					wp_x[it.path_index] = it.pos_x;
					wp_y[it.path_index] = it.pos_y;
					if (it.path_last) path_len = it.path_index + 1;
				end
				REQ_ODOM: begin
					rob_x = it.pos_x;
					rob_y = it.pos_y;
					rob_heading = it.heading;
					rob_speed = it.speed;
					pose_ok = 1;
				end
				REQ_COMPUTE: begin
					r = '0;
					if (!pose_ok) r.status = ST_NO_POSE;
					else if (path_len == 0) r.status = ST_EMPTY;
					else begin
						v = (rob_speed < $signed(SPEED_FLOOR)) ? def_speed : 64'(rob_speed);
						ld = ((gain * v) >> 16) + offset;
						nearest = 0;
						best = dist_sq(0);
						for (int i = 1; i < path_len; i++) begin
							d = dist_sq(i);
							if (d < best) begin
								best = d;
								nearest = i;
							end
						end
						ld2 = {64'd0, ld} * {64'd0, ld};
						target = path_len - 1;
						for (int i = nearest; i < path_len; i++) begin
							if (dist_sq(i) >= ld2) begin
								target = i;
								break;
							end
						end
						r.linear_speed = v[31:0];
						r.target_index = 10'(target);
						if (ld == 0) r.status = ST_ZERO_LD;
						else begin
							alpha = bearing_of(longint'(wp_x[target]) - longint'(rob_x),
								longint'(wp_y[target]) - longint'(rob_y)) - rob_heading;
							s = sine_q30(alpha);
							ms = 64'(s < 0 ? -s : s);
							num = 64'd2 * v * ms;
							den = ld << 14;
							q = num / den;
							if (s >= 0)
								r.angular_speed = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
							else begin
								if (q > 64'h8000_0000) q = 64'h8000_0000;
								r.angular_speed = 32'd0 - q[31:0];
							end
							r.status = ST_OK;
						end
					end
					steer_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_rsp(rsp_item_t got);
			rsp_item_t want;
			if (steer_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = steer_q.pop_front();
			if (got.linear_speed !== want.linear_speed)
				report($sformatf("linear_speed %0d, expected %0d",
					got.linear_speed, want.linear_speed));
			if (got.angular_speed !== want.angular_speed)
				report($sformatf("angular_speed %0d, expected %0d",
					got.angular_speed, want.angular_speed));
			if (got.target_index !== want.target_index)
				report($sformatf("target_index %0d, expected %0d",
					got.target_index, want.target_index));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles = 0;
	bit written [PATH_DEPTH];
	steer_scoreboard sb;

	pps_if #(.item_t(req_item_t)) req_ch ();
	pps_if #(.item_t(rsp_item_t)) rsp_ch ();

	pure_pursuit_steering dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) sb.check_rsp(rsp_ch.data);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic req_item_t make_req(req_t kind, logic [9:0] idx, logic last,
		logic [31:0] x, logic [31:0] y, logic [15:0] hd, logic [31:0] spd);
		req_item_t it;
		it.req_type = kind;
		it.path_index = idx;
		it.path_last = last;
		it.pos_x = x;
		it.pos_y = y;
		it.heading = hd;
		it.speed = spd;
		return it;
	endfunction

	// Mostly positions within a few tens of metres, so lookahead scans do real work.
	function automatic logic [31:0] rand_pos();
		if ($urandom_range(3) == 0) return $urandom;
		return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
	endfunction

	function automatic logic [31:0] rand_speed();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(200);
			2: return 32'(-$signed($urandom_range(32'h0002_0000)));
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	task automatic send_req(req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid = 0;
		end
		@(negedge clk);
		req_ch.valid = 1;
		req_ch.data = it;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_req(it);
		if (it.req_type == REQ_PATH) written[it.path_index] = 1;
	endtask

	task automatic send_path(int n);
		for (int i = 0; i < n; i++)
			send_req(make_req(REQ_PATH, 10'(i), i == n - 1, rand_pos(), rand_pos(),
				16'($urandom), $urandom));
	endtask

	task automatic settle(int extra);
		@(negedge clk);
		req_ch.valid = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		sb.set_cfg(idx, val);
	endtask

	task automatic run_random(int count);
		int sent;
		int roll;
		int idx;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				idx = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
				send_path(idx);
				sent += idx;
			end else if (roll < 55) begin
				send_req(make_req(REQ_ODOM, 10'($urandom), 1'($urandom), rand_pos(),
					rand_pos(), 16'($urandom), rand_speed()));
				sent++;
			end else if (roll < 88) begin
				send_req(make_req(REQ_COMPUTE, 10'($urandom), 1'($urandom), $urandom,
					$urandom, 16'($urandom), $urandom));
				sent++;
			end else if (roll < 94) begin
				send_req(make_req(REQ_NONE, 10'($urandom), 1'($urandom), $urandom,
					$urandom, 16'($urandom), $urandom));
			end else begin
				// Stray write anywhere; the last flag is kept only when every lower slot holds data.
				idx = $urandom_range(PATH_DEPTH - 1);
				roll = 1;
				for (int i = 0; i < idx; i++) if (!written[i]) roll = 0;
				send_req(make_req(REQ_PATH, 10'(idx), roll && $urandom_range(1), $urandom,
					$urandom, 16'($urandom), $urandom));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_GAIN;
		cfg_data = '0;
		req_ch.valid = 0;
		req_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: no pose, empty path, extreme fields, target on the robot.
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_ODOM, 10'h3FF, 1, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h8000, 32'h8000_0000));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_NONE, 10'h3FF, 1, '1, '1, '1, '1));
		send_req(make_req(REQ_PATH, 10'h3FF, 0, '1, '1, '1, '1));
		send_req(make_req(REQ_PATH, 10'd0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
		send_req(make_req(REQ_PATH, 10'd1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
		send_req(make_req(REQ_PATH, 10'd2, 1, 32'h0001_0000, 32'h0002_0000, 0, 0));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_ODOM, 0, 0, 32'h0001_0000, 32'h0002_0000, 16'h7FFF, 32'd65));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_ODOM, 0, 0, 0, 0, 16'h4000, 32'd66));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_ODOM, 0, 0, 32'h8000_0000, 32'h8000_0000, 16'hC000,
			32'h7FFF_FFFF));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_ODOM, 0, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_PATH, 10'd0, 1, 32'h0000_8000, 0, 0, 0));
		send_req(make_req(REQ_COMPUTE, '0, 0, 0, 0, 0, 0));
		settle(20);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					write_cfg(CFG_GAIN, '0);
					write_cfg(CFG_OFFSET, '0);
					write_cfg(CFG_DEFSPEED, '0);
				end
				2: begin
					write_cfg(CFG_GAIN, '1);
					write_cfg(CFG_OFFSET, '1);
					write_cfg(CFG_DEFSPEED, '1);
				end
				3: begin
					// Tiny lookahead with a fast default speed drives the turn rate into saturation.
					write_cfg(CFG_GAIN, 31'd1);
					write_cfg(CFG_OFFSET, 31'd1);
					write_cfg(CFG_DEFSPEED, '1);
				end
				4: begin
					write_cfg(CFG_GAIN, $urandom_range(32'h0003_0000));
					write_cfg(CFG_OFFSET, $urandom_range(32'h0002_0000));
					write_cfg(CFG_DEFSPEED, $urandom_range(32'h0002_0000));
				end
				default: ;
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 50; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 50; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			run_random(phase == 1 ? 30 : 56);
			settle(20);
		end

		settle(300);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
